### src/smslm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smslm_pkg;

  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned SQUARE_W  = 31;
  localparam int unsigned MEAN_W    = 31;
  localparam int unsigned WIDTH_W   = 8;
  localparam int unsigned FRAMES_W  = 32;
  localparam int unsigned SUM_W     = 64;
  localparam int unsigned DIVISOR_W = 32;
  localparam int unsigned SHIFT_W   = 5;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic signed [LEVEL_W-1:0] SAT_MAX   = 16'sh7FFF;
  localparam logic signed [LEVEL_W-1:0] SAT_MIN   = 16'sh8000;
  localparam logic [WIDTH_W-1:0]        WIDTH_MAX = 8'd255;

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic {
    REG_MONO_MODE   = 1'b0,
    REG_INPUT_SHIFT = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ_MID,
    S_SQ_SIDE,
    S_ACC_SIDE,
    S_DIV_MID,
    S_DIV_SIDE,
    S_DIV_WIDTH,
    S_OUT
  } state_e;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] mid;
    logic signed [LEVEL_W-1:0] side;
  } midside_t;

  typedef struct packed {
    logic                 start;
    logic [SUM_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_ctl_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

### src/smslm_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface smslm_in_if;
  import smslm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [1:0]                 op;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;

  modport source (output valid, op, left_sample, right_sample, input ready);
  modport sink   (input valid, op, left_sample, right_sample, output ready);
endinterface

interface smslm_out_if;
  import smslm_pkg::*;

  logic                valid;
  logic                ready;
  logic [MEAN_W-1:0]   mean_mid_square;
  logic [MEAN_W-1:0]   mean_side_square;
  logic [LEVEL_W-1:0]  peak_mid_level;
  logic [WIDTH_W-1:0]  stereo_width;
  logic [FRAMES_W-1:0] frames_counted;
  logic                has_frames;

  modport source (output valid, mean_mid_square, mean_side_square, peak_mid_level,
                  stereo_width, frames_counted, has_frames, input ready);
  modport sink   (input valid, mean_mid_square, mean_side_square, peak_mid_level,
                  stereo_width, frames_counted, has_frames, output ready);
endinterface

`default_nettype wire

### src/smslm_shaper.sv
`timescale 1ns / 1ps
`default_nettype none

module smslm_shaper (
  input  wire logic signed [smslm_pkg::SAMPLE_W-1:0] left_sample_i,
  input  wire logic signed [smslm_pkg::SAMPLE_W-1:0] right_sample_i,
  input  wire logic                                  mono_mode_i,
  input  wire logic [smslm_pkg::SHIFT_W-1:0]         input_shift_i,
  output smslm_pkg::midside_t                        ms_o
);
  import smslm_pkg::*;

  function automatic logic signed [LEVEL_W-1:0] shape(
    input logic signed [SAMPLE_W-1:0] raw,
    input logic [SHIFT_W-1:0]         sh
  );
    logic signed [SAMPLE_W-1:0] x;
    x = raw >>> sh;
    if (x > SAMPLE_W'(SAT_MAX)) begin
      return SAT_MAX;
    end else if (x < SAMPLE_W'(SAT_MIN)) begin
      return SAT_MIN;
    end
    return x[LEVEL_W-1:0];
  endfunction

  logic signed [LEVEL_W-1:0] l_s, r_s;
  logic [LEVEL_W:0] sum, dif, sum_adj, dif_adj;

  always_comb begin
    l_s = shape(left_sample_i, input_shift_i);
    r_s = mono_mode_i ? l_s : shape(right_sample_i, input_shift_i);
    sum = {l_s[LEVEL_W-1], l_s} + {r_s[LEVEL_W-1], r_s};
    dif = {l_s[LEVEL_W-1], l_s} - {r_s[LEVEL_W-1], r_s};
    // round negative halves toward zero before the shift
    sum_adj = sum + {{LEVEL_W{1'b0}}, sum[LEVEL_W]};
    dif_adj = dif + {{LEVEL_W{1'b0}}, dif[LEVEL_W]};
    ms_o.mid  = sum_adj[LEVEL_W:1];
    ms_o.side = dif_adj[LEVEL_W:1];
  end

endmodule

`default_nettype wire

### src/smslm_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module smslm_divider (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  smslm_pkg::div_ctl_t  ctl_i,
  output smslm_pkg::div_rsp_t  rsp_o
);
  import smslm_pkg::*;

  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);

  logic [CNT_W-1:0]     cnt_q;
  logic                 done_q;
  logic [SUM_W-1:0]     quo_q, quo_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d, div_q;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_q, quo_q[SUM_W-1]};
    fits  = trial >= {1'b0, div_q};
    rem_d = fits ? DIVISOR_W'(trial - {1'b0, div_q}) : trial[DIVISOR_W-1:0];
    quo_d = {quo_q[SUM_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        cnt_q <= CNT_W'(DIV_STEPS);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      quo_q <= ctl_i.dividend;
      rem_q <= '0;
      div_q <= ctl_i.divisor;
    end else if (cnt_q != '0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

### src/stereo_mid_side_level_meter_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake        Carries
// req_i     in   valid/ready      op, left_sample, right_sample
// res_o     out  valid/ready      means, peak, width, frame count, has_frames
// apb       in   psel/penable     mono_mode (0x0), input_shift (0x4)
//
// Frame request: accept, then mid square, side square, accumulate;
// only the accept once the frame count has saturated. Clear and unused op: accept only.
// Read: the shared 1-bit-per-cycle divider (load plus 64 steps) runs mid mean, side
// mean and width in turn (width only if the mid mean is nonzero), then the result loads.
// Reset is asynchronous and clears all accumulators at once; no sweep.
// A finished read waits in the result register while further requests are taken;
// a second read holds off input until that result is taken.
module stereo_mid_side_level_meter_top #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [smslm_pkg::APB_AW-1:0] paddr,
  input  wire logic [smslm_pkg::APB_DW-1:0] pwdata,
  output logic [smslm_pkg::APB_DW-1:0]      prdata,
  output logic                              pready,
  smslm_in_if.sink                          req_i,
  smslm_out_if.source                       res_o
);
  import smslm_pkg::*;

  state_e state_q, state_d;

  logic                   mono_q;
  logic [SHIFT_W-1:0]     shift_q;
  logic [SUM_W-1:0]       msum_q, ssum_q;
  logic [LEVEL_W-1:0]     peak_q;
  logic [COUNT_WIDTH-1:0] total_q;

  logic signed [LEVEL_W-1:0] mid_q, side_q, mul_op;
  logic signed [2*LEVEL_W-1:0] prod_full;
  logic [SQUARE_W-1:0]       prod_q;
  logic [LEVEL_W:0]          mid_abs;

  logic [MEAN_W-1:0]  mm_q, ms_q;
  logic [WIDTH_W-1:0] width_q;
  logic               has_q;
  logic [MEAN_W+WIDTH_W-1:0] scaled;

  logic                out_valid_q;
  logic [MEAN_W-1:0]   out_mm_q, out_ms_q;
  logic [LEVEL_W-1:0]  out_peak_q;
  logic [WIDTH_W-1:0]  out_width_q;
  logic [FRAMES_W-1:0] out_frames_q;
  logic                out_has_q;

  midside_t ms;
  div_ctl_t div_ctl;
  div_rsp_t div_rsp;

  logic in_acc, cfg_wr, saturated, no_frames, load_out;
  op_e  op;

  smslm_shaper u_shaper (
    .left_sample_i  (req_i.left_sample),
    .right_sample_i (req_i.right_sample),
    .mono_mode_i    (mono_q),
    .input_shift_i  (shift_q),
    .ms_o           (ms)
  );

  smslm_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .rsp_o  (div_rsp)
  );

  assign op        = op_e'(req_i.op);
  assign in_acc    = req_i.valid && req_i.ready;
  assign saturated = &total_q;
  assign no_frames = (total_q == '0);
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_MONO_MODE:   prdata = APB_DW'(mono_q);
      REG_INPUT_SHIFT: prdata = APB_DW'(shift_q);
      default:         prdata = '0;
    endcase
  end

  // side mean times 255 as a shift and subtract
  assign scaled = {div_rsp.quotient[MEAN_W-1:0], {WIDTH_W{1'b0}}}
                - (MEAN_W+WIDTH_W)'(div_rsp.quotient[MEAN_W-1:0]);

  assign mul_op    = (state_q == S_SQ_SIDE) ? side_q : mid_q;
  assign prod_full = (2*LEVEL_W)'(mul_op) * (2*LEVEL_W)'(mul_op);
  assign mid_abs   = mid_q[LEVEL_W-1] ? -{mid_q[LEVEL_W-1], mid_q} : {1'b0, mid_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (op)
            OP_FRAME: if (!saturated) state_d = S_SQ_MID;
            OP_READ:  state_d = no_frames ? S_OUT : S_DIV_MID;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_SQ_MID:   state_d = S_SQ_SIDE;
      S_SQ_SIDE:  state_d = S_ACC_SIDE;
      S_ACC_SIDE: state_d = S_IDLE;
      S_DIV_MID: begin
        if (div_rsp.done) state_d = S_DIV_SIDE;
      end
      S_DIV_SIDE: begin
        if (div_rsp.done) state_d = (mm_q == '0) ? S_OUT : S_DIV_WIDTH;
      end
      S_DIV_WIDTH: begin
        if (div_rsp.done) state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || res_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req_i.ready      = 1'b0;
    load_out         = 1'b0;
    div_ctl.start    = 1'b0;
    div_ctl.dividend = msum_q;
    div_ctl.divisor  = DIVISOR_W'(total_q);
    unique case (state_q)
      S_IDLE: begin
        req_i.ready   = 1'b1;
        div_ctl.start = in_acc && (op == OP_READ) && !no_frames;
      end
      S_DIV_MID: begin
        div_ctl.start    = div_rsp.done;
        div_ctl.dividend = ssum_q;
      end
      S_DIV_SIDE: begin
        div_ctl.start    = div_rsp.done && (mm_q != '0);
        div_ctl.dividend = SUM_W'(scaled);
        div_ctl.divisor  = DIVISOR_W'(mm_q);
      end
      S_OUT: load_out = !out_valid_q || res_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mono_q      <= 1'b0;
      shift_q     <= '0;
      msum_q      <= '0;
      ssum_q      <= '0;
      peak_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        unique case (reg_idx_e'(paddr[2]))
          REG_MONO_MODE:   mono_q  <= pwdata[0];
          REG_INPUT_SHIFT: shift_q <= pwdata[SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (state_q == S_IDLE && in_acc && op == OP_CLEAR) begin
        msum_q  <= '0;
        ssum_q  <= '0;
        peak_q  <= '0;
        total_q <= '0;
      end
      if (state_q == S_SQ_MID) begin
        total_q <= total_q + COUNT_WIDTH'(1);
        if (mid_abs[LEVEL_W-1:0] > peak_q) peak_q <= mid_abs[LEVEL_W-1:0];
      end
      if (state_q == S_SQ_SIDE) msum_q <= msum_q + SUM_W'(prod_q);
      if (state_q == S_ACC_SIDE) ssum_q <= ssum_q + SUM_W'(prod_q);
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_acc) begin
      mid_q  <= ms.mid;
      side_q <= ms.side;
      has_q  <= !no_frames;
    end
    if (state_q == S_SQ_MID || state_q == S_SQ_SIDE) begin
      prod_q <= prod_full[SQUARE_W-1:0];
    end
    if (div_rsp.done) begin
      unique case (state_q)
        S_DIV_MID: mm_q <= div_rsp.quotient[MEAN_W-1:0];
        S_DIV_SIDE: begin
          ms_q    <= div_rsp.quotient[MEAN_W-1:0];
          width_q <= '0;
        end
        S_DIV_WIDTH: begin
          width_q <= (|div_rsp.quotient[SUM_W-1:WIDTH_W]) ? WIDTH_MAX
                                                          : div_rsp.quotient[WIDTH_W-1:0];
        end
        default: ;
      endcase
    end
    if (load_out) begin
      out_has_q    <= has_q;
      out_mm_q     <= has_q ? mm_q : '0;
      out_ms_q     <= has_q ? ms_q : '0;
      out_width_q  <= has_q ? width_q : '0;
      out_peak_q   <= has_q ? peak_q : '0;
      out_frames_q <= has_q ? FRAMES_W'(total_q) : '0;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.mean_mid_square  = out_mm_q;
  assign res_o.mean_side_square = out_ms_q;
  assign res_o.peak_mid_level   = out_peak_q;
  assign res_o.stereo_width     = out_width_q;
  assign res_o.frames_counted   = out_frames_q;
  assign res_o.has_frames       = out_has_q;

endmodule

`default_nettype wire

### src/smslm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module smslm_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_ready_i,
  input wire logic [1:0]                      in_op_i,
  input wire logic                            out_valid_i,
  input wire logic [smslm_pkg::MEAN_W-1:0]    mean_mid_i,
  input wire logic [smslm_pkg::MEAN_W-1:0]    mean_side_i,
  input wire logic [smslm_pkg::LEVEL_W-1:0]   peak_i,
  input wire logic [smslm_pkg::WIDTH_W-1:0]   width_i,
  input wire logic [smslm_pkg::FRAMES_W-1:0]  frames_i,
  input wire logic                            has_i
);
  import smslm_pkg::*;

  // input is not ready in the cycle after a read is taken
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i == OP_READ |=> !in_ready_i)
    else $error("ready after read request");

  a_clear_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i == OP_CLEAR |=> in_ready_i)
    else $error("clear request stalled input");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a busy read");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !has_i |-> mean_mid_i == '0 && mean_side_i == '0 &&
                              peak_i == '0 && width_i == '0 && frames_i == '0)
    else $error("empty result carries nonzero fields");

  a_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> has_i == (frames_i != '0))
    else $error("has_frames disagrees with frame count");

endmodule

bind stereo_mid_side_level_meter_top smslm_checker u_smslm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .in_op_i     (req_i.op),
  .out_valid_i (res_o.valid),
  .mean_mid_i  (res_o.mean_mid_square),
  .mean_side_i (res_o.mean_side_square),
  .peak_i      (res_o.peak_mid_level),
  .width_i     (res_o.stereo_width),
  .frames_i    (res_o.frames_counted),
  .has_i       (res_o.has_frames)
);

`default_nettype wire
